// ===== hw/rtl/bmprle_pkg.sv =====
// ============================================================================
// BMP RLE stream validator package
// Shared types and constants for the RLE8/RLE4 payload validator.
// ============================================================================
package bmprle_pkg;

    // Width of the column and row counters and of the size registers.
    localparam int unsigned DIM_W = 15;
    // Width of the configuration write data.
    localparam int unsigned CFG_DATA_W = 15;
    // Width of the configuration register index.
    localparam int unsigned CFG_IDX_W = 2;
    // Width of the palette size register.
    localparam int unsigned PAL_W = 9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COLORS = 2'd3;

    // Configuration reset values.
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = 15'd1;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = 15'd1;
    localparam logic             RST_EIGHT_BIT_MODE = 1'b1;
    localparam logic [PAL_W-1:0] RST_PALETTE_COLORS = 9'd256;

    // Escape codes that follow a zero count byte.
    localparam logic [7:0] ESC_END_OF_LINE   = 8'd0;
    localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
    localparam logic [7:0] ESC_DELTA         = 8'd2;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_COUNT,
        PH_CODE,
        PH_DX,
        PH_DY,
        PH_LIT,
        PH_SWALLOW
    } t_phase;

    // Outcome of one byte.
    typedef enum logic [1:0] {
        V_NONE,
        V_BAD,
        V_GOOD
    } t_verdict;

endpackage

// ===== hw/rtl/bmp_rle_stream_validator_top.sv =====
// ============================================================================
// BMP RLE stream validator
// Checks a BMP RLE8/RLE4 compressed payload byte by byte against the
// configured image size and palette, and gives one valid/invalid verdict.
// ============================================================================
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_stream_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_stall  | o_stream_valid
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// The block takes one byte per cycle while the output is not stalled. A byte
// is first captured in an input register and is parsed from there, and the
// verdict that it decides is then registered in the output register.
// The sustained rate of one byte per cycle is set by the single parse stage,
// which updates column, row and the literal counters for one byte a cycle.
// Reset is synchronous and active low; it clears the parser, both valid
// flags and restores the configuration registers to their reset values.
// When the output is stalled with a verdict waiting, one more byte is still
// taken into the input register if it is empty; then the input stalls too.
// Configuration writes are always accepted into the configuration registers.
// ============================================================================
module bmp_rle_stream_validator_top #(
    parameter int unsigned MAX_DIMENSION = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Payload input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_stream_byte,
    input  logic                              i_last_byte,
    // Verdict output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_stream_valid,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bmprle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmprle_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bmprle_pkg::*;

    localparam int unsigned CMP_W = 17;

    // Configuration registers.
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             r_eight;
    logic [PAL_W-1:0] r_palette;

    // Input register.
    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_last;

    // Output register.
    logic             r_out_valid;
    logic             r_out_data;

    // Parser state.
    t_phase           r_phase,     n_phase;
    logic [DIM_W-1:0] r_column,    n_column;
    logic [DIM_W-1:0] r_row,       n_row;
    logic [7:0]       r_count,     n_count;
    logic [7:0]       r_lit_pix,   n_lit_pix;
    logic [7:0]       r_lit_bytes, n_lit_bytes;

    t_verdict         verdict;
    logic             emit;
    logic             advance;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [DIM_W-1:0] room;
    logic             row_full;
    logic [7:0]       lit_bytes;
    logic [7:0]       pix_after_hi;

    // The parse stage moves whenever the output register is free or being
    // emptied in this cycle.
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_stream_valid = r_out_data;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_IMAGE_WIDTH;
            r_height  <= RST_IMAGE_HEIGHT;
            r_eight   <= RST_EIGHT_BIT_MODE;
            r_palette <= RST_PALETTE_COLORS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_width   <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:   r_height  <= i_cfg_data[DIM_W-1:0];
                CFG_EIGHT_BIT_MODE: r_eight   <= i_cfg_data[0];
                CFG_PALETTE_COLORS: r_palette <= i_cfg_data[PAL_W-1:0];
                default:            r_width   <= r_width;
            endcase
        end
    end

    // Input register: loads whenever it is empty or its item moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_stream_byte;
            r_last <= i_last_byte;
        end
    end

    // Sizes above the bound are used as the bound.
    assign eff_w = ({2'b00, r_width} > CMP_W'(MAX_DIMENSION)) ?
                   DIM_W'(MAX_DIMENSION) : r_width;
    assign eff_h = ({2'b00, r_height} > CMP_W'(MAX_DIMENSION)) ?
                   DIM_W'(MAX_DIMENSION) : r_height;

    // Pixels left in the current row; zero once the column has run past it.
    assign room     = (r_column >= eff_w) ? '0 : (eff_w - r_column);
    assign row_full = (r_row >= eff_h);

    // Bytes a literal occupies, rounded up to a whole 16-bit word, minus one.
    // In RLE4 two pixels share a byte. The largest case is 255 in RLE8.
    always_comb begin
        logic [8:0] data_bytes;
        logic [8:0] padded;
        data_bytes = r_eight ? {1'b0, r_byte} : ({1'b0, r_byte} + 9'd1) >> 1;
        padded     = (data_bytes + 9'd1) & ~9'd1;
        lit_bytes  = 8'(padded - 9'd1);
    end

    assign pix_after_hi = (r_lit_pix != 8'd0) ? (r_lit_pix - 8'd1) : 8'd0;

    function automatic logic bad_index(input logic [7:0] idx,
                                       input logic [PAL_W-1:0] colors);
        return {1'b0, idx} >= colors;
    endfunction

    // Next state and verdict for the byte in the input register.
    always_comb begin
        n_phase     = r_phase;
        n_column    = r_column;
        n_row       = r_row;
        n_count     = r_count;
        n_lit_pix   = r_lit_pix;
        n_lit_bytes = r_lit_bytes;
        verdict     = V_NONE;
        emit        = 1'b0;

        if (r_in_valid && advance) begin
            if (r_phase == PH_SWALLOW) begin
                // A verdict has been given; drop bytes up to the last one.
                if (r_last) begin
                    n_phase = PH_COUNT;
                end
            end else begin
                case (r_phase)
                    PH_COUNT: begin
                        n_count = r_byte;
                        n_phase = PH_CODE;
                    end
                    PH_CODE: begin
                        if (r_count != 8'd0) begin
                            // Encoded run: count pixels of one index or index pair.
                            if (row_full || ({7'd0, r_count} > room)) begin
                                verdict = V_BAD;
                            end else if (r_eight && bad_index(r_byte, r_palette)) begin
                                verdict = V_BAD;
                            end else if (!r_eight &&
                                         (bad_index({4'd0, r_byte[7:4]}, r_palette) ||
                                          (r_count > 8'd1 &&
                                           bad_index({4'd0, r_byte[3:0]}, r_palette)))) begin
                                verdict = V_BAD;
                            end else begin
                                n_column = r_column + DIM_W'(r_count);
                                n_phase  = PH_COUNT;
                            end
                        end else if (r_byte == ESC_END_OF_BITMAP) begin
                            verdict = V_GOOD;
                        end else if (r_byte == ESC_END_OF_LINE) begin
                            if (row_full) begin
                                verdict = V_BAD;
                            end else begin
                                n_column = '0;
                                n_row    = r_row + DIM_W'(1);
                                n_phase  = PH_COUNT;
                            end
                        end else if (r_byte == ESC_DELTA) begin
                            n_phase = PH_DX;
                        end else begin
                            // Absolute mode: a literal of r_byte pixels follows.
                            if (row_full || ({7'd0, r_byte} > room)) begin
                                verdict = V_BAD;
                            end else begin
                                n_lit_pix   = r_byte;
                                n_lit_bytes = lit_bytes;
                                n_column    = r_column + DIM_W'(r_byte);
                                n_phase     = PH_LIT;
                            end
                        end
                    end
                    PH_DX: begin
                        if (row_full || ({7'd0, r_byte} > room)) begin
                            verdict = V_BAD;
                        end else begin
                            n_column = r_column + DIM_W'(r_byte);
                            n_phase  = PH_DY;
                        end
                    end
                    PH_DY: begin
                        if (row_full || ({7'd0, r_byte} >= (eff_h - r_row))) begin
                            verdict = V_BAD;
                        end else begin
                            n_row   = r_row + DIM_W'(r_byte);
                            n_phase = PH_COUNT;
                        end
                    end
                    PH_LIT: begin
                        // Pad bytes after the last pixel pass unchecked.
                        if (r_eight) begin
                            if (r_lit_pix != 8'd0 && bad_index(r_byte, r_palette)) begin
                                verdict = V_BAD;
                            end
                            n_lit_pix = pix_after_hi;
                        end else begin
                            if (r_lit_pix != 8'd0 &&
                                bad_index({4'd0, r_byte[7:4]}, r_palette)) begin
                                verdict = V_BAD;
                            end else if (pix_after_hi != 8'd0 &&
                                         bad_index({4'd0, r_byte[3:0]}, r_palette)) begin
                                verdict = V_BAD;
                            end
                            n_lit_pix = (pix_after_hi != 8'd0) ?
                                        (pix_after_hi - 8'd1) : 8'd0;
                        end
                        if (r_lit_bytes == 8'd0) begin
                            n_phase = PH_COUNT;
                        end else begin
                            n_lit_bytes = r_lit_bytes - 8'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_COUNT;
                    end
                endcase

                // A last byte without end-of-bitmap is a truncated payload.
                if (verdict != V_NONE || r_last) begin
                    emit = 1'b1;
                    n_phase = r_last ? PH_COUNT : PH_SWALLOW;
                end
            end

            // Restart clears the position and counters.
            if (r_last) begin
                n_phase     = PH_COUNT;
                n_column    = '0;
                n_row       = '0;
                n_count     = 8'd0;
                n_lit_pix   = 8'd0;
                n_lit_bytes = 8'd0;
            end
        end
    end

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COUNT;
            r_column    <= '0;
            r_row       <= '0;
            r_count     <= 8'd0;
            r_lit_pix   <= 8'd0;
            r_lit_bytes <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_column    <= n_column;
            r_row       <= n_row;
            r_count     <= n_count;
            r_lit_pix   <= n_lit_pix;
            r_lit_bytes <= n_lit_bytes;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_data <= (verdict == V_GOOD);
        end
    end

endmodule

// ===== hw/rtl/bmprle_checker.sv =====
// ============================================================================
// BMP RLE stream validator checker
// Port-level assertions on the validator top level, attached by bind.
// ============================================================================
module bmprle_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_stream_valid,
    input logic o_cfg_ready
);

    // A stalled verdict holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_stream_valid))
        else $error("stalled verdict changed or vanished");

    // The input only backs up when a verdict waits on a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled verdict");

    // No verdict is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

    // The configuration port never pushes back.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind bmp_rle_stream_validator_top bmprle_checker u_bmprle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_stream_valid (o_stream_valid),
    .o_cfg_ready    (o_cfg_ready)
);
